// ===== design/csvs_pkg.sv =====
// Shared types and constants for the CSV line cell splitter.
// Used by every module of the block but csvs_ram; no dependencies of its own.
`default_nettype none

package csvs_pkg;

  // Cell buffer depth and derived widths
  localparam int CELL_MAX = 64;
  localparam int AW       = $clog2(CELL_MAX);
  localparam int CW       = $clog2(CELL_MAX + 1);

  localparam logic [CW-1:0] CELL_MAX_C = CW'(CELL_MAX);

  // Characters with a meaning of their own
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef logic [CW-1:0] cnt_t;
  typedef logic [AW-1:0] addr_t;

  // Closed cell handed from the buffer side to the emitter
  typedef struct packed {
    logic start;
    cnt_t lo;
    cnt_t hi;
    logic line;
    logic ovf;
    logic qerr;
  } cell_desc_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_START,
    EM_DEC
  } emit_state_t;

endpackage

`default_nettype wire

// ===== design/csvs_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module csvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== design/csvs_buf.sv =====
// Input side: buffers cell bytes into the RAM, tracks quote parity and overflow,
// and hands a closed cell to the emitter. Depends on csvs_pkg.
`default_nettype none

module csvs_buf
  import csvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  output logic            we,
  output addr_t           waddr,
  output logic [7:0]      wdata,
  output cell_desc_t      desc
);

  cnt_t       fill_r, fill_nxt;
  logic       parity_r, parity_nxt;
  logic       ovf_r, ovf_nxt;
  logic [7:0] first_r;
  logic [7:0] last_r;

  logic is_nl, is_comma, is_quote, close, store, full, strip;

  assign is_nl    = (text_byte == CH_NEWLINE);
  assign is_comma = (text_byte == CH_COMMA);
  assign is_quote = (text_byte == CH_QUOTE);
  assign close    = accept && (is_nl || (is_comma && !parity_r));
  assign store    = accept && !close;
  assign full     = (fill_r == CELL_MAX_C);

  // Write the byte at the fill position while room is left
  assign we    = store && !full;
  assign waddr = fill_r[AW-1:0];
  assign wdata = text_byte;

  // Describe the closed cell: strip an enclosing quote pair
  assign strip = (fill_r != '0) && (first_r == CH_QUOTE) && (last_r == CH_QUOTE);

  always_comb begin
    desc.start = close;
    desc.line  = is_nl;
    desc.qerr  = is_nl && parity_r;
    desc.ovf   = ovf_r;
    if (strip) begin
      if (fill_r == CW'(1)) begin
        desc.lo = '0;
        desc.hi = '0;
      end else begin
        desc.lo = CW'(1);
        desc.hi = fill_r - CW'(1);
      end
    end else begin
      desc.lo = '0;
      desc.hi = fill_r;
    end
  end

  // Advance fill count, parity and overflow flag
  always_comb begin
    fill_nxt   = fill_r;
    parity_nxt = parity_r;
    ovf_nxt    = ovf_r;
    if (close) begin
      fill_nxt   = '0;
      parity_nxt = 1'b0;
      ovf_nxt    = 1'b0;
    end else if (store) begin
      if (is_quote) begin
        parity_nxt = !parity_r;
      end
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      parity_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      parity_r <= parity_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // Keep first and last stored bytes for the quote strip test
  always_ff @(posedge clk) begin
    if (we) begin
      last_r <= text_byte;
      if (fill_r == '0) begin
        first_r <= text_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/csvs_emit.sv =====
// Emitter: walks the stored cell in the RAM, collapses doubled quotes and
// drives the output register. Depends on csvs_pkg.
`default_nettype none

module csvs_emit
  import csvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_desc_t desc,
  input  wire logic [7:0] rdata_a,
  input  wire logic [7:0] rdata_b,
  output addr_t           raddr_a,
  output addr_t           raddr_b,
  output logic            busy,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_cell_byte,
  output logic            out_byte_valid,
  output logic            out_cell_end,
  output logic            out_line_end,
  output logic            out_overflow,
  output logic            out_quote_error
);

  emit_state_t state_r, state_nxt;
  cnt_t        p_r, p_nxt;
  cnt_t        hi_r, hi_nxt;
  logic        line_r, ovf_r, qerr_r;
  logic        line_nxt, ovf_nxt, qerr_nxt;

  logic       ov_r;
  logic [7:0] ob_r;
  logic       obv_r, oend_r, oline_r, oovf_r, oqerr_r;

  logic          slot_free, pair, last, load;
  logic          ld_valid, ld_end;
  logic [7:0]    ld_byte;
  logic [CW:0]   p_plus1, p_step;

  assign slot_free = !ov_r || !out_stall;

  // Decode the current position: a quote followed by a quote consumes two
  assign p_plus1 = {1'b0, p_r} + (CW+1)'(1);
  assign pair    = (rdata_a == CH_QUOTE) && (p_plus1 < {1'b0, hi_r}) && (rdata_b == CH_QUOTE);
  assign p_step  = pair ? (p_plus1 + (CW+1)'(1)) : p_plus1;
  assign last    = (p_step >= {1'b0, hi_r});

  // Next state, position and output load
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    hi_nxt    = hi_r;
    line_nxt  = line_r;
    ovf_nxt   = ovf_r;
    qerr_nxt  = qerr_r;
    load      = 1'b0;
    ld_byte   = 8'h00;
    ld_valid  = 1'b0;
    ld_end    = 1'b1;
    case (state_r)
      EM_IDLE: begin
        if (desc.start) begin
          state_nxt = EM_START;
          p_nxt     = desc.lo;
          hi_nxt    = desc.hi;
          line_nxt  = desc.line;
          ovf_nxt   = desc.ovf;
          qerr_nxt  = desc.qerr;
        end
      end
      EM_START: begin
        if (p_r >= hi_r) begin
          // Empty cell: one marker item
          if (slot_free) begin
            load      = 1'b1;
            state_nxt = EM_IDLE;
          end
        end else begin
          state_nxt = EM_DEC;
        end
      end
      EM_DEC: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_byte  = rdata_a;
          ld_valid = 1'b1;
          ld_end   = last;
          p_nxt    = p_step[CW-1:0];
          if (last) begin
            state_nxt = EM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  // Read ahead at the next position when advancing, else hold the address
  assign raddr_a = (state_r == EM_DEC && slot_free) ? p_step[AW-1:0] : p_r[AW-1:0];
  assign raddr_b = raddr_a + AW'(1);
  assign busy    = (state_r != EM_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    hi_r   <= hi_nxt;
    line_r <= line_nxt;
    ovf_r  <= ovf_nxt;
    qerr_r <= qerr_nxt;
    if (load) begin
      ob_r    <= ld_byte;
      obv_r   <= ld_valid;
      oend_r  <= ld_end;
      oline_r <= line_r;
      oovf_r  <= ovf_r;
      oqerr_r <= qerr_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_cell_byte   = ob_r;
  assign out_byte_valid  = obv_r;
  assign out_cell_end    = oend_r;
  assign out_line_end    = oline_r;
  assign out_overflow    = oovf_r;
  assign out_quote_error = oqerr_r;

endmodule

`default_nettype wire

// ===== design/csv_line_cell_splitter.sv =====
// CSV line cell splitter, top level. A closing byte (separating comma or newline)
// moves the emitter into a setup state that also loads an empty cell's marker,
// then, for a non-empty cell, into a decode state that gives one result item per
// cycle while the output is not stalled. Input stalls until the walk of the cell
// RAM ends. Synchronous reset clears fill count, parity, overflow flag, emitter
// state and out_valid.
`default_nettype none

module csv_line_cell_splitter
  import csvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_cell_byte,
  output logic            out_byte_valid,
  output logic            out_cell_end,
  output logic            out_line_end,
  output logic            out_overflow,
  output logic            out_quote_error
);

  logic       accept, we, busy;
  addr_t      waddr, raddr_a, raddr_b;
  logic [7:0] wdata, rdata_a, rdata_b;
  cell_desc_t desc;

  // Hold input while a cell is being emitted
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  csvs_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_text_byte),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .desc      (desc)
  );

  csvs_ram #(
    .WIDTH (8),
    .DEPTH (CELL_MAX)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  csvs_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .desc            (desc),
    .rdata_a         (rdata_a),
    .rdata_b         (rdata_b),
    .raddr_a         (raddr_a),
    .raddr_b         (raddr_b),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_byte   (out_cell_byte),
    .out_byte_valid  (out_byte_valid),
    .out_cell_end    (out_cell_end),
    .out_line_end    (out_line_end),
    .out_overflow    (out_overflow),
    .out_quote_error (out_quote_error)
  );

  // An empty cell marker is always the last item of its cell
  a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> out_cell_end)
    else $error("empty cell marker without cell_end");

  // A newline closes the cell and blocks input in the next cycle
  a_nl_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_text_byte == CH_NEWLINE) |=> in_stall)
    else $error("newline did not start cell emission");

  // Quote errors only come with a newline-closed cell
  a_qerr_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_quote_error) |-> out_line_end)
    else $error("quote_error without line_end");

  // Never write the RAM while a cell is being walked
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !we)
    else $error("cell RAM written during emission");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for csv_line_cell_splitter: sends text bytes, predicts the decoded cells.
// Depends on csvs_pkg and the splitter RTL only.
`timescale 1ns / 100ps

module tb
  import csvs_pkg::*;
();

  localparam int RANDOM_ITEMS = 310;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 40;

  // One decoded result of a cell
  typedef struct {
    logic [7:0] cell_byte;
    logic       byte_valid;
    logic       cell_end;
    logic       line_end;
    logic       overflow;
    logic       quote_error;
  } cell_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_cell_byte;
  logic       out_byte_valid;
  logic       out_cell_end;
  logic       out_line_end;
  logic       out_overflow;
  logic       out_quote_error;

  // Predictor state: buffered raw bytes, count, quote parity, overflow flag
  logic [7:0] raw_cell [CELL_MAX];
  int         raw_fill;
  logic       parity_odd;
  logic       truncated;

  cell_item_t cells_due[$];
  int         error_count;
  int         items_sent;
  int         burst_left;
  int         cycle_count;

  csv_line_cell_splitter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_byte  (out_cell_byte),
    .out_byte_valid (out_byte_valid),
    .out_cell_end   (out_cell_end),
    .out_line_end   (out_line_end),
    .out_overflow   (out_overflow),
    .out_quote_error(out_quote_error)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("[%0d] mismatch: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  // Decode the buffered cell and queue its result items, then clear the cell
  function automatic void close_cell(input logic line, input logic qerr);
    int         lo;
    int         hi;
    int         p;
    logic [7:0] c;
    logic [7:0] decoded[$];
    cell_item_t r;
    lo = 0;
    hi = raw_fill;
    if (raw_fill > 0 && raw_cell[0] == CH_QUOTE && raw_cell[raw_fill-1] == CH_QUOTE) begin
      if (raw_fill == 1) begin
        hi = 0;
      end else begin
        lo = 1;
        hi = raw_fill - 1;
      end
    end
    // Collapse each doubled quote to one
    p = lo;
    while (p < hi) begin
      c = raw_cell[p];
      if (c == CH_QUOTE && p + 1 < hi && raw_cell[p+1] == CH_QUOTE) p++;
      decoded.push_back(c);
      p++;
    end
    r.line_end    = line;
    r.overflow    = truncated;
    r.quote_error = qerr;
    if (decoded.size() == 0) begin
      r.cell_byte  = 8'h00;
      r.byte_valid = 1'b0;
      r.cell_end   = 1'b1;
      cells_due.push_back(r);
    end else begin
      foreach (decoded[i]) begin
        r.cell_byte  = decoded[i];
        r.byte_valid = 1'b1;
        r.cell_end   = (i == decoded.size() - 1);
        cells_due.push_back(r);
      end
    end
    raw_fill   = 0;
    parity_odd = 1'b0;
    truncated  = 1'b0;
  endfunction

  // Advance the predictor by one accepted text byte
  function automatic void predict_text_byte(input logic [7:0] c);
    if (c == CH_NEWLINE) begin
      close_cell(1'b1, parity_odd);
    end else if (c == CH_COMMA && !parity_odd) begin
      close_cell(1'b0, 1'b0);
    end else begin
      if (c == CH_QUOTE) parity_odd = ~parity_odd;
      if (raw_fill < CELL_MAX) begin
        raw_cell[raw_fill] = c;
        raw_fill++;
      end else begin
        truncated = 1'b1;
      end
    end
  endfunction

  // Present one item, hold it until accepted, then maybe pause between bursts
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid     <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_text_byte(b);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Any byte that is not a quote, comma or newline
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_QUOTE || b == CH_COMMA || b == CH_NEWLINE);
    return b;
  endfunction

  // Any byte, with the special characters picked often
  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 5))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_NEWLINE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Check the result channel
  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk) begin : check_results
    cell_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cells_due.size() == 0) begin
        report_mismatch($sformatf("result %0h with nothing expected", out_cell_byte));
      end else begin
        want = cells_due.pop_front();
        check_field("cell_byte", out_cell_byte, want.cell_byte);
        check_field("byte_valid", 8'(out_byte_valid), 8'(want.byte_valid));
        check_field("cell_end", 8'(out_cell_end), 8'(want.cell_end));
        check_field("line_end", 8'(out_line_end), 8'(want.line_end));
        check_field("overflow", 8'(out_overflow), 8'(want.overflow));
        check_field("quote_error", 8'(out_quote_error), 8'(want.quote_error));
      end
    end
  end

  // Stall the result channel in stretches of varying density
  initial begin : stall_pattern
    int stall_pct;
    int span;
    forever begin
      stall_pct = 25 * $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(posedge clk);
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Cycle limit guard
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // Plain text cells, including the extreme byte values
  task automatic test_plain_cells();
    send_text("ab,c\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_COMMA);
  endtask

  // Empty cells: no bytes, a pair of quotes, a lone quote
  task automatic test_empty_cells();
    send_text(",\n");
    send_text("\"\",");
    send_text("\"\n");
  endtask

  // Quoted text with a kept comma and a doubled quote
  task automatic test_quoted_cells();
    send_text("\"a,b\",");
    send_text("\"x\"\"y\"\n");
  endtask

  // Newline arriving with odd quote parity
  task automatic test_odd_newline();
    send_text("a\"b\n");
  endtask

  // Full buffer: drop bytes, still toggle parity on dropped quotes
  task automatic test_overflow();
    for (int i = 0; i < CELL_MAX; i++) send_byte(plain_byte());
    send_text("\",\",");
    send_byte(CH_QUOTE);
    for (int i = 0; i < CELL_MAX - 2; i++) send_byte(plain_byte());
    send_text("\"\n");
  endtask

  // Mostly well-formed lines with random content, plus noise and broken quoting
  task automatic test_random_lines();
    int start;
    int cells;
    int len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      cells = $urandom_range(1, 5);
      for (int k = 0; k < cells; k++) begin
        case ($urandom_range(0, 39))
          0: begin
            len = $urandom_range(CELL_MAX - 4, CELL_MAX + 6);
            for (int i = 0; i < len; i++) send_byte(plain_byte());
          end
          1, 2, 3, 4: begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) send_byte(noisy_byte());
          end
          5, 6, 7: begin
            send_byte(CH_QUOTE);
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) send_byte(plain_byte());
          end
          default: begin
            if ($urandom_range(0, 1)) begin
              len = $urandom_range(0, 6);
              for (int i = 0; i < len; i++) send_byte(plain_byte());
            end else begin
              send_byte(CH_QUOTE);
              len = $urandom_range(0, 6);
              for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 4))
                  0: send_byte(CH_COMMA);
                  1: send_text("\"\"");
                  default: send_byte(plain_byte());
                endcase
              end
              send_byte(CH_QUOTE);
            end
          end
        endcase
        send_byte((k == cells - 1) ? CH_NEWLINE : CH_COMMA);
      end
    end
  endtask

  initial begin : main
    raw_fill    = 0;
    parity_odd  = 1'b0;
    truncated   = 1'b0;
    error_count = 0;
    items_sent  = 0;
    burst_left  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_cells();
    test_empty_cells();
    test_quoted_cells();
    test_odd_newline();
    test_overflow();
    test_random_lines();

    // Drain the remaining results
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cells_due.size() != 0) begin
      report_mismatch($sformatf("%0d result items never arrived", cells_due.size()));
    end

    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/csvs_pkg.sv
design/csvs_ram.sv
design/csvs_buf.sv
design/csvs_emit.sv
design/csv_line_cell_splitter.sv
tb/tb.sv
